// ===== rtl/core/b2c_pkg.sv =====
// b2c_pkg: shared types and constants for the bitplane to chunky converter
// no dependencies; used by every module in rtl/core

package b2c_pkg;

    localparam int PLANE_NUM    = 8;   // plane bytes carried by one request
    localparam int PIX_PER_BYTE = 8;   // pixels packed in one plane byte
    localparam int QUEUE_DEPTH  = 2;   // items held between front and back

    // configuration register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_WIDTH_PIXELS    = 2'd0;
    localparam logic [1:0] REG_ROW_PITCH_BYTES = 2'd1;
    localparam logic [1:0] REG_FRAME_HEIGHT    = 2'd2;
    localparam logic [1:0] REG_PLANE_COUNT     = 2'd3;

    // register reset values
    localparam logic [10:0] RST_WIDTH_PIXELS    = 11'd16;
    localparam logic [7:0]  RST_ROW_PITCH_BYTES = 8'd2;
    localparam logic [10:0] RST_FRAME_HEIGHT    = 11'd16;
    localparam logic [3:0]  RST_PLANE_COUNT     = 4'd5;

    typedef struct packed {
        logic [10:0] width_pixels;
        logic [7:0]  row_pitch_bytes;
        logic [10:0] frame_height;
        logic [3:0]  plane_count;
    } cfg_t;

    // one classified item waiting for the back end
    typedef struct packed {
        logic [PLANE_NUM-1:0][7:0]  plane_bytes; // unused planes already zeroed
        logic [6:0]                 byte_column;
        logic [9:0]                 row_number;
        logic [PIX_PER_BYTE-1:0]    visible;     // bit b: pixel b is in the row
        logic [PIX_PER_BYTE-1:0]    frame_end;   // bit b: pixel b ends the frame
    } item_t;

endpackage

// ===== rtl/core/b2c_planes_if.sv =====
// b2c_planes_if: valid/ready channel carrying one byte of each bitplane
// depends on nothing; used by the clocked modules that drive it

interface b2c_planes_if;
    logic       valid;
    logic       ready;
    logic [7:0] plane0_byte;
    logic [7:0] plane1_byte;
    logic [7:0] plane2_byte;
    logic [7:0] plane3_byte;
    logic [7:0] plane4_byte;
    logic [7:0] plane5_byte;
    logic [7:0] plane6_byte;
    logic [7:0] plane7_byte;

    modport source (
        output valid, plane0_byte, plane1_byte, plane2_byte, plane3_byte,
               plane4_byte, plane5_byte, plane6_byte, plane7_byte,
        input  ready
    );
    modport sink (
        input  valid, plane0_byte, plane1_byte, plane2_byte, plane3_byte,
               plane4_byte, plane5_byte, plane6_byte, plane7_byte,
        output ready
    );
endinterface

// ===== rtl/core/b2c_pixels_if.sv =====
// b2c_pixels_if: valid/ready channel carrying one chunky pixel
// depends on nothing; used by the clocked modules that drive it

interface b2c_pixels_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_index;
    logic [9:0] pixel_x;
    logic [9:0] pixel_y;
    logic       last_of_item;
    logic       end_of_frame;

    modport source (
        output valid, pixel_index, pixel_x, pixel_y, last_of_item, end_of_frame,
        input  ready
    );
    modport sink (
        input  valid, pixel_index, pixel_x, pixel_y, last_of_item, end_of_frame,
        output ready
    );
endinterface

// ===== rtl/core/b2c_queue.sv =====
// b2c_queue: short register fifo of classified items between front and back
// depends on b2c_pkg (item_t, QUEUE_DEPTH)

module b2c_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  b2c_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output b2c_pkg::item_t head_item
);
    import b2c_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t             store_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_item = store_reg[rd_ptr_reg];

    // pointer and fill count updates
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // item storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/core/b2c_front.sv =====
// b2c_front: accepts plane-byte requests, tracks column and row, classifies pixels
// depends on b2c_pkg (cfg_t, item_t) and b2c_planes_if

module b2c_front #(
    parameter int MAX_PLANES = 8,
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic           clk,
    input  logic           rst_n,
    input  b2c_pkg::cfg_t  cfg,
    b2c_planes_if.sink     planes,
    input  logic           queue_full,
    output logic           push,
    output b2c_pkg::item_t push_item
);
    import b2c_pkg::*;

    localparam logic [9:0]  PITCH_LIM  = 10'(MAX_WIDTH / PIX_PER_BYTE);
    localparam logic [12:0] HEIGHT_LIM = 13'(MAX_HEIGHT);
    localparam logic [3:0]  PLANE_LIM  = 4'(MAX_PLANES);

    logic [6:0]  byte_column_reg, byte_column_next;
    logic [9:0]  row_number_reg, row_number_next;

    logic [7:0]  pitch_nz, pitch_eff;
    logic [10:0] height_nz;
    logic [12:0] height_eff;
    logic [3:0]  planes_eff;
    logic        final_row;
    logic        row_done;
    logic [10:0] row_pixels, last_x;
    logic [10:0] x_pos [PIX_PER_BYTE];
    logic        accept;
    logic [PLANE_NUM-1:0][7:0] in_bytes;

    assign accept       = planes.valid && planes.ready;
    assign planes.ready = !queue_full;

    assign in_bytes = {planes.plane7_byte, planes.plane6_byte, planes.plane5_byte,
                       planes.plane4_byte, planes.plane3_byte, planes.plane2_byte,
                       planes.plane1_byte, planes.plane0_byte};

    // effective pitch, height and plane count after clamping
    always_comb
    begin
        pitch_nz   = (cfg.row_pitch_bytes == '0) ? 8'd1 : cfg.row_pitch_bytes;
        pitch_eff  = ({2'b00, pitch_nz} > PITCH_LIM) ? PITCH_LIM[7:0] : pitch_nz;
        height_nz  = (cfg.frame_height == '0) ? 11'd1 : cfg.frame_height;
        height_eff = ({2'b00, height_nz} > HEIGHT_LIM) ? HEIGHT_LIM : {2'b00, height_nz};
        planes_eff = (cfg.plane_count > PLANE_LIM) ? PLANE_LIM : cfg.plane_count;
    end

    // row position and visible row length
    always_comb
    begin
        final_row  = ({3'b000, row_number_reg} + 13'd1) >= height_eff;
        row_done   = ({1'b0, byte_column_reg} + 8'd1) >= pitch_eff;
        row_pixels = ({pitch_eff, 3'b000} < cfg.width_pixels) ?
                     {pitch_eff, 3'b000} : cfg.width_pixels;
        last_x     = (row_pixels == '0) ? '0 : row_pixels - 11'd1;
    end

    // per-pixel classification and plane masking
    always_comb
    begin
        push_item.byte_column = byte_column_reg;
        push_item.row_number  = row_number_reg;
        for (int b = 0; b < PIX_PER_BYTE; b++)
        begin
            x_pos[b] = {1'b0, byte_column_reg, 3'(b)};
            push_item.visible[b]   = x_pos[b] < cfg.width_pixels;
            push_item.frame_end[b] = final_row && (x_pos[b] == last_x);
        end
        for (int p = 0; p < PLANE_NUM; p++)
        begin
            push_item.plane_bytes[p] = (4'(p) < planes_eff) ? in_bytes[p] : 8'h00;
        end
    end

    // items made only of padding advance the position but enter no queue
    assign push = accept && (push_item.visible != '0);

    // column and row counters
    always_comb
    begin
        byte_column_next = byte_column_reg;
        row_number_next  = row_number_reg;
        if (accept)
        begin
            if (row_done)
            begin
                byte_column_next = '0;
                row_number_next  = final_row ? '0 : row_number_reg + 10'd1;
            end
            else
            begin
                byte_column_next = byte_column_reg + 7'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_column_reg <= '0;
            row_number_reg  <= '0;
        end
        else
        begin
            byte_column_reg <= byte_column_next;
            row_number_reg  <= row_number_next;
        end
    end

endmodule

// ===== rtl/core/b2c_back.sv =====
// b2c_back: walks the visible pixels of each queued item, one pixel per cycle unless the pixel output stalls
// depends on b2c_pkg (item_t) and b2c_pixels_if

module b2c_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           queue_not_empty,
    input  b2c_pkg::item_t head_item,
    output logic           pop,
    b2c_pixels_if.source   pixels
);
    import b2c_pkg::*;

    item_t                   cur_reg;
    logic [PIX_PER_BYTE-1:0] remain_reg, remain_next;
    logic                    out_valid_reg, out_valid_next;
    logic [7:0]              index_reg;
    logic [9:0]              x_reg;
    logic [9:0]              y_reg;
    logic                    last_reg;
    logic                    eof_reg;

    logic                    busy;
    logic                    advance;
    logic [2:0]              sel_bit;
    logic [PIX_PER_BYTE-1:0] remain_cleared;
    logic [7:0]              sel_index;

    assign busy    = (remain_reg != '0);
    assign advance = busy && (!out_valid_reg || pixels.ready);

    // leftmost pixel still pending
    always_comb
    begin
        sel_bit = '0;
        for (int b = PIX_PER_BYTE - 1; b >= 0; b--)
        begin
            if (remain_reg[b])
            begin
                sel_bit = 3'(b);
            end
        end
        remain_cleared          = remain_reg;
        remain_cleared[sel_bit] = 1'b0;
    end

    // gather the chosen bit of every plane
    always_comb
    begin
        for (int p = 0; p < PLANE_NUM; p++)
        begin
            sel_index[p] = cur_reg.plane_bytes[p][3'd7 - sel_bit];
        end
    end

    // take the next item as the current one runs out
    assign pop = queue_not_empty && (!busy || (advance && (remain_cleared == '0)));

    always_comb
    begin
        remain_next = advance ? remain_cleared : remain_reg;
        if (pop)
        begin
            remain_next = head_item.visible;
        end
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (pixels.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // current item and output pixel payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head_item;
        end
        if (advance)
        begin
            index_reg <= sel_index;
            x_reg     <= {cur_reg.byte_column, sel_bit};
            y_reg     <= cur_reg.row_number;
            last_reg  <= (remain_cleared == '0);
            eof_reg   <= cur_reg.frame_end[sel_bit];
        end
    end

    assign pixels.valid        = out_valid_reg;
    assign pixels.pixel_index  = index_reg;
    assign pixels.pixel_x      = x_reg;
    assign pixels.pixel_y      = y_reg;
    assign pixels.last_of_item = last_reg;
    assign pixels.end_of_frame = eof_reg;

endmodule

// ===== rtl/core/bitplane_to_chunky_converter_core.sv =====
// bitplane_to_chunky_converter_core: top level with register port, front, queue, back
// depends on b2c_pkg, b2c_planes_if, b2c_pixels_if, b2c_front, b2c_queue, b2c_back
//
//  channel   direction  handshake             carries
//  planes    in         valid/ready           plane0_byte .. plane7_byte
//  pixels    out        valid/ready           pixel_index, pixel_x, pixel_y, flags
//  apb       in         psel/penable/pready   width, pitch, height, plane count
//
// one pixel leaves per cycle unless the pixel output stalls; only visible pixels
// are emitted, and padding-only items advance the front but enter no queue.
// the front takes a request whenever the two-entry queue has room, so requests keep
// flowing while the output register holds a stalled pixel, until the queue fills.
// reset clears column, row, queue and output valid; registers return to defaults.
// pixels pass through the queue, the current-item register and the output register.

module bitplane_to_chunky_converter_core #(
    parameter int MAX_PLANES = 8,
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    b2c_planes_if.sink  planes,
    b2c_pixels_if.source pixels,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import b2c_pkg::*;

    cfg_t  cfg_reg, cfg_next;
    logic  cfg_write;
    logic  q_push, q_full, q_pop, q_not_empty;
    item_t q_push_item, q_head_item;

    // register write port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (paddr[3:2])
                REG_WIDTH_PIXELS:    cfg_next.width_pixels    = pwdata[10:0];
                REG_ROW_PITCH_BYTES: cfg_next.row_pitch_bytes = pwdata[7:0];
                REG_FRAME_HEIGHT:    cfg_next.frame_height    = pwdata[10:0];
                REG_PLANE_COUNT:     cfg_next.plane_count     = pwdata[3:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width_pixels    <= RST_WIDTH_PIXELS;
            cfg_reg.row_pitch_bytes <= RST_ROW_PITCH_BYTES;
            cfg_reg.frame_height    <= RST_FRAME_HEIGHT;
            cfg_reg.plane_count     <= RST_PLANE_COUNT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // register read mux
    always_comb
    begin
        case (paddr[3:2])
            REG_WIDTH_PIXELS:    prdata = {21'd0, cfg_reg.width_pixels};
            REG_ROW_PITCH_BYTES: prdata = {24'd0, cfg_reg.row_pitch_bytes};
            REG_FRAME_HEIGHT:    prdata = {21'd0, cfg_reg.frame_height};
            REG_PLANE_COUNT:     prdata = {28'd0, cfg_reg.plane_count};
            default:             prdata = '0;
        endcase
    end

    // front: accept and classify
    b2c_front #(
        .MAX_PLANES (MAX_PLANES),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .planes     (planes),
        .queue_full (q_full),
        .push       (q_push),
        .push_item  (q_push_item)
    );

    // queue between front and back
    b2c_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_item (q_head_item)
    );

    // back: emit pixels
    b2c_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .queue_not_empty (q_not_empty),
        .head_item       (q_head_item),
        .pop             (q_pop),
        .pixels          (pixels)
    );

endmodule
